>>> design/bla_pkg.sv
`timescale 1ns / 1ps
package bla_pkg;

  localparam int unsigned PendDepthDef = 64;
  localparam int unsigned GrpDepthDef  = 16;
  localparam int unsigned SectorShift  = 9;

  localparam logic [7:0] KIND_WRITE   = 8'h57;  // 'W'
  localparam logic [7:0] KIND_DISCARD = 8'h44;  // 'D'

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_ISSUE_FULL = 3'd1,
    ST_UNMATCHED  = 3'd2,
    ST_ERROR      = 3'd3,
    ST_ACCOUNTED  = 3'd4,
    ST_STATS_FULL = 3'd5
  } bla_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSCAN,
    S_PDEC,
    S_GSCAN,
    S_GDEC,
    S_OUT
  } bla_state_e;

  typedef struct packed {
    logic        latch_in;
    logic        scan_clr;
    logic        scan_run;
    logic        scan_grp;
    logic        pend_wr;
    logic        pend_clr;
    logic        grp_wr;
    logic        stage_res;
    bla_status_e st;
    logic        load_out;
  } bla_cmd_t;

  typedef struct packed {
    logic op;
    logic failed;
    logic scan_done;
    logic hit;
    logic free;
    logic out_free;
  } bla_stat_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] group;
    logic [63:0] tstamp;
    logic        wr;
    logic [31:0] nbytes;
  } bla_pend_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] rd_bytes;
    logic [63:0] wr_bytes;
    logic [63:0] rd_ios;
    logic [63:0] wr_ios;
    logic [63:0] rd_lat;
    logic [63:0] wr_lat;
  } bla_grp_t;

endpackage

>>> design/bla_ctrl.sv
`timescale 1ns / 1ps
module bla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bla_pkg::bla_stat_t stat_i,
  output bla_pkg::bla_cmd_t  cmd_o
);
  import bla_pkg::*;

  bla_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.st   = ST_STORED;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_PSCAN;
        end
      end
      S_PSCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_PDEC;
        end
      end
      S_PDEC: begin
        cmd_o.stage_res = 1'b1;
        state_d         = S_OUT;
        if (!stat_i.op) begin
          if (stat_i.hit || stat_i.free) begin
            cmd_o.pend_wr = 1'b1;
            cmd_o.st      = ST_STORED;
          end else begin
            cmd_o.st = ST_ISSUE_FULL;
          end
        end else if (!stat_i.hit) begin
          cmd_o.st = ST_UNMATCHED;
        end else begin
          cmd_o.pend_clr = 1'b1;
          if (stat_i.failed) begin
            cmd_o.st = ST_ERROR;
          end else begin
            cmd_o.stage_res = 1'b0;
            cmd_o.scan_clr  = 1'b1;
            state_d         = S_GSCAN;
          end
        end
      end
      S_GSCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.scan_grp = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_GDEC;
        end
      end
      S_GDEC: begin
        cmd_o.scan_grp  = 1'b1;
        cmd_o.stage_res = 1'b1;
        if (stat_i.hit || stat_i.free) begin
          cmd_o.grp_wr = 1'b1;
          cmd_o.st     = ST_ACCOUNTED;
        end else begin
          cmd_o.st = ST_STATS_FULL;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/bla_dp.sv
`timescale 1ns / 1ps
module bla_dp #(
  parameter int unsigned PENDING_DEPTH = bla_pkg::PendDepthDef,
  parameter int unsigned GROUP_DEPTH   = bla_pkg::GrpDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bla_pkg::bla_cmd_t        cmd_i,
  output bla_pkg::bla_stat_t       stat_o,
  input  logic                     in_op_i,
  input  logic [31:0]              in_device_i,
  input  logic [31:0]              in_sector_i,
  input  logic [63:0]              in_time_i,
  input  logic [63:0]              in_group_i,
  input  logic [7:0]               in_kind_i,
  input  logic [31:0]              in_bytes_i,
  input  logic [22:0]              in_nsec_i,
  input  logic                     in_failed_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bla_pkg::bla_status_e     out_status_o,
  output logic [63:0]              out_group_o,
  output logic                     out_write_o,
  output logic [63:0]              out_latency_o,
  output logic [63:0]              out_tbytes_o,
  output logic [63:0]              out_tios_o,
  output logic [63:0]              out_tlat_o
);
  import bla_pkg::*;

  localparam int unsigned PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned GIW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int unsigned SCW = ((PIW > GIW) ? PIW : GIW) + 1;
  localparam logic [SCW-1:0] PLim = SCW'(PENDING_DEPTH);
  localparam logic [SCW-1:0] GLim = SCW'(GROUP_DEPTH);

  // latched item
  logic        op_q, failed_q, wr_in_q;
  logic [63:0] key_q, time_q, gid_q;
  logic [31:0] bytes_in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q       <= in_op_i;
      failed_q   <= in_failed_i;
      key_q      <= {in_device_i, in_sector_i};
      time_q     <= in_time_i;
      gid_q      <= in_group_i;
      wr_in_q    <= (in_kind_i == KIND_WRITE) || (in_kind_i == KIND_DISCARD);
      bytes_in_q <= (in_bytes_i != 32'd0) ? in_bytes_i
                                          : {in_nsec_i, {SectorShift{1'b0}}};
    end
  end

  // scan sequencer
  logic [SCW-1:0] cnt_q, ridx_q, limit;
  logic           rv_q, rd_en, hit_q, free_q;
  logic [PIW-1:0] p_hidx_q, p_fidx_q, p_wr_idx;
  logic [GIW-1:0] g_hidx_q, g_fidx_q, g_wr_idx;

  assign limit = cmd_i.scan_grp ? GLim : PLim;
  assign rd_en = cmd_i.scan_run && (cnt_q != limit);

  bla_pend_t pend_mem [PENDING_DEPTH];
  bla_pend_t pend_rd_q, pent_q, pend_wdata;
  logic [PENDING_DEPTH-1:0] pend_valid_q;

  bla_grp_t grp_mem [GROUP_DEPTH];
  bla_grp_t grp_rd_q, grow_q, grp_new;
  logic [GROUP_DEPTH-1:0] grp_valid_q;

  logic [63:0] lat_q;

  assign p_wr_idx = hit_q ? p_hidx_q : p_fidx_q;
  assign g_wr_idx = hit_q ? g_hidx_q : g_fidx_q;

  always_comb begin
    pend_wdata        = '0;
    pend_wdata.key    = key_q;
    pend_wdata.group  = gid_q;
    pend_wdata.tstamp = time_q;
    pend_wdata.wr     = wr_in_q;
    pend_wdata.nbytes = bytes_in_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_wr) begin
      pend_mem[p_wr_idx] <= pend_wdata;
    end
    if (rd_en && !cmd_i.scan_grp) begin
      pend_rd_q <= pend_mem[cnt_q[PIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grp_wr) begin
      grp_mem[g_wr_idx] <= grp_new;
    end
    if (rd_en && cmd_i.scan_grp) begin
      grp_rd_q <= grp_mem[cnt_q[GIW-1:0]];
    end
  end

  logic cmp_v, cmp_match;
  always_comb begin
    if (cmd_i.scan_grp) begin
      cmp_v     = grp_valid_q[ridx_q[GIW-1:0]];
      cmp_match = cmp_v && (grp_rd_q.id == pent_q.group);
    end else begin
      cmp_v     = pend_valid_q[ridx_q[PIW-1:0]];
      cmp_match = cmp_v && (pend_rd_q.key == key_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rv_q   <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      cnt_q  <= '0;
      rv_q   <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      rv_q <= rd_en;
      if (rd_en) begin
        cnt_q <= cnt_q + SCW'(1);
      end
      if (rv_q && cmp_match && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (rv_q && !cmp_v && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run && rd_en) begin
      ridx_q <= cnt_q;
    end
    if (cmd_i.scan_run && rv_q && cmp_match && !hit_q) begin
      if (cmd_i.scan_grp) begin
        g_hidx_q <= ridx_q[GIW-1:0];
        grow_q   <= grp_rd_q;
      end else begin
        p_hidx_q <= ridx_q[PIW-1:0];
        pent_q   <= pend_rd_q;
      end
    end
    if (cmd_i.scan_run && rv_q && !cmp_v && !free_q) begin
      if (cmd_i.scan_grp) begin
        g_fidx_q <= ridx_q[GIW-1:0];
      end else begin
        p_fidx_q <= ridx_q[PIW-1:0];
      end
    end
    lat_q <= time_q - pent_q.tstamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= '0;
      grp_valid_q  <= '0;
    end else begin
      if (cmd_i.pend_wr) begin
        pend_valid_q[p_wr_idx] <= 1'b1;
      end
      if (cmd_i.pend_clr) begin
        pend_valid_q[p_hidx_q] <= 1'b0;
      end
      if (cmd_i.grp_wr) begin
        grp_valid_q[g_wr_idx] <= 1'b1;
      end
    end
  end

  // group totals update
  logic [63:0] nb64;
  assign nb64 = {32'd0, pent_q.nbytes};

  always_comb begin
    grp_new = '0;
    if (hit_q) begin
      grp_new = grow_q;
    end else begin
      grp_new.id = pent_q.group;
    end
    if (pent_q.wr) begin
      grp_new.wr_bytes = grp_new.wr_bytes + nb64;
      grp_new.wr_ios   = grp_new.wr_ios + 64'd1;
      grp_new.wr_lat   = grp_new.wr_lat + lat_q;
    end else begin
      grp_new.rd_bytes = grp_new.rd_bytes + nb64;
      grp_new.rd_ios   = grp_new.rd_ios + 64'd1;
      grp_new.rd_lat   = grp_new.rd_lat + lat_q;
    end
  end

  // staged result and output register
  bla_status_e res_st_q;
  logic        res_wr_q;
  logic [63:0] res_grp_q, res_lat_q, res_tb_q, res_ti_q, res_tl_q;
  logic        acc;
  assign acc = (cmd_i.st == ST_ACCOUNTED);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_res) begin
      res_st_q  <= cmd_i.st;
      res_wr_q  <= acc && pent_q.wr;
      res_grp_q <= acc ? pent_q.group : 64'd0;
      res_lat_q <= acc ? lat_q : 64'd0;
      res_tb_q  <= !acc ? 64'd0 : (pent_q.wr ? grp_new.wr_bytes : grp_new.rd_bytes);
      res_ti_q  <= !acc ? 64'd0 : (pent_q.wr ? grp_new.wr_ios : grp_new.rd_ios);
      res_tl_q  <= !acc ? 64'd0 : (pent_q.wr ? grp_new.wr_lat : grp_new.rd_lat);
    end
    if (cmd_i.load_out) begin
      out_status_o  <= res_st_q;
      out_write_o   <= res_wr_q;
      out_group_o   <= res_grp_q;
      out_latency_o <= res_lat_q;
      out_tbytes_o  <= res_tb_q;
      out_tios_o    <= res_ti_q;
      out_tlat_o    <= res_tl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.failed    = failed_q;
  assign stat_o.scan_done = (cnt_q == limit) && !rv_q;
  assign stat_o.hit       = hit_q;
  assign stat_o.free      = free_q;
  assign stat_o.out_free  = !out_valid_o || out_ready_i;

  a_wr_clr_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.pend_wr && cmd_i.pend_clr)) else $error("pending write and free together");

  a_pend_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pend_wr |-> (hit_q || free_q)) else $error("pending write without slot");

  a_grp_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grp_wr |=> grp_valid_q[$past(g_wr_idx)]) else $error("group entry not marked");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_o || out_ready_i)) else $error("result overwritten");

endmodule

>>> design/block_io_latency_accounting.sv
`timescale 1ns / 1ps
// Storage request latency accounting. Issue words (tuser = 0) store the request
// under the key {device, sector_low} in a pending table; complete words (tuser = 1)
// find and free that entry and, unless failed or the group table is full, add
// bytes, one I/O and the wrapping latency to the read or write totals of the group
// recorded at issue. Every input word gives exactly one result word whose tuser
// holds the status code. Both tables sit in single-port memories that are searched
// one entry per clock; an issue or a failed/unmatched completion scans the pending
// table, and a matched, not failed completion then scans the group table too. One
// word is in flight at a time, and the finished result waits in an output register
// while the next word may be taken. Tables come out of reset empty with no clearing pass.
module block_io_latency_accounting #(
  parameter int unsigned PENDING_DEPTH = bla_pkg::PendDepthDef,
  parameter int unsigned GROUP_DEPTH   = bla_pkg::GrpDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // device, sector_low, timestamp, group_id, kind_char, byte_count,
  // sector_count, failed
  input  logic [255:0] s_axis_tdata,
  // op
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_group, out_write, latency, total_bytes, total_ios, total_latency, zero pad
  output logic [327:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser
);
  import bla_pkg::*;

  bla_cmd_t    cmd;
  bla_stat_t   stat;
  bla_status_e out_status;
  logic        out_write;
  logic [63:0] out_group, out_latency, out_tbytes, out_tios, out_tlat;

  bla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bla_dp #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .GROUP_DEPTH   (GROUP_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_op_i       (s_axis_tuser),
    .in_device_i   (s_axis_tdata[31:0]),
    .in_sector_i   (s_axis_tdata[63:32]),
    .in_time_i     (s_axis_tdata[127:64]),
    .in_group_i    (s_axis_tdata[191:128]),
    .in_kind_i     (s_axis_tdata[199:192]),
    .in_bytes_i    (s_axis_tdata[231:200]),
    .in_nsec_i     (s_axis_tdata[254:232]),
    .in_failed_i   (s_axis_tdata[255]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (out_status),
    .out_group_o   (out_group),
    .out_write_o   (out_write),
    .out_latency_o (out_latency),
    .out_tbytes_o  (out_tbytes),
    .out_tios_o    (out_tios),
    .out_tlat_o    (out_tlat)
  );

  // result word packing, lowest field first
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {7'd0, out_tlat, out_tios, out_tbytes, out_latency,
                         out_write, out_group};

endmodule

>>> bench/block_io_latency_accounting_tb.sv
`timescale 1ns / 1ps
module block_io_latency_accounting_tb;
  import bla_pkg::*;

  localparam int unsigned PendN = 64;
  localparam int unsigned GrpN  = 16;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // device, sector_low, timestamp, group_id, kind_char, byte_count, sector_count, failed
  logic [255:0] s_axis_tdata = '0;
  // op
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_group, out_write, latency, total_bytes, total_ios, total_latency
  logic [327:0] m_axis_tdata;
  // status
  logic [2:0]   m_axis_tuser;

  block_io_latency_accounting u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  // expected result word: status in [330:328], packed tdata below
  typedef logic [330:0] acct_word_t;
  acct_word_t acct_q[$];

  // shadow of the block's tables
  logic        pv[PendN];
  logic [63:0] pkey[PendN], pgrp[PendN], ptime[PendN];
  logic        pwr[PendN];
  logic [31:0] pbytes[PendN];
  logic        gv[GrpN];
  logic [63:0] gid[GrpN], gbytes[GrpN][2], gios[GrpN][2], glat[GrpN][2];

  int  mism = 0;
  bit  failed_any = 0;
  bit  hold_rx = 0;
  // keys recently issued, reused by completions
  logic [63:0] live_keys[$];
  logic [63:0] grp_pool[24];

  // compute the status and totals an event produces, update the shadow tables
  function automatic acct_word_t account_event(logic op, logic [31:0] dev, logic [31:0] sec,
      logic [63:0] now, logic [63:0] grp, logic [7:0] kind, logic [31:0] nb,
      logic [22:0] nsec, logic fail);
    logic [63:0] key, lat;
    int p, g, fr;
    logic w;
    bla_status_e st;
    acct_word_t r;
    key = {dev, sec};
    r = '0;
    p = -1;
    for (int i = 0; i < PendN; i++) if (p < 0 && pv[i] && pkey[i] == key) p = i;
    if (!op) begin
      if (p < 0) for (int i = 0; i < PendN; i++) if (p < 0 && !pv[i]) p = i;
      if (p < 0) st = ST_ISSUE_FULL;
      else begin
        pv[p] = 1; pkey[p] = key; pgrp[p] = grp; ptime[p] = now;
        pwr[p] = (kind == KIND_WRITE || kind == KIND_DISCARD);
        pbytes[p] = (nb != 0) ? nb : {nsec, 9'd0};
        st = ST_STORED;
      end
    end else if (p < 0) st = ST_UNMATCHED;
    else begin
      pv[p] = 0;
      if (fail) st = ST_ERROR;
      else begin
        g = -1; fr = -1;
        for (int i = 0; i < GrpN; i++) begin
          if (g < 0 && gv[i] && gid[i] == pgrp[p]) g = i;
          if (fr < 0 && !gv[i]) fr = i;
        end
        if (g < 0 && fr >= 0) begin
          g = fr; gv[g] = 1; gid[g] = pgrp[p];
          for (int d = 0; d < 2; d++) begin
            gbytes[g][d] = 0; gios[g][d] = 0; glat[g][d] = 0;
          end
        end
        if (g < 0) st = ST_STATS_FULL;
        else begin
          w = pwr[p];
          lat = now - ptime[p];
          gbytes[g][w] += pbytes[p];
          gios[g][w] += 1;
          glat[g][w] += lat;
          st = ST_ACCOUNTED;
          r[327:0] = {7'd0, glat[g][w], gios[g][w], gbytes[g][w], lat, w, pgrp[p]};
        end
      end
    end
    r[330:328] = st;
    return r;
  endfunction

  // burst/gap state of the sender
  int burst_left = 0;

  task automatic send_word(logic op, logic [31:0] dev, logic [31:0] sec, logic [63:0] now,
      logic [63:0] grp, logic [7:0] kind, logic [31:0] nb, logic [22:0] nsec, logic fail);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {fail, nsec, nb, kind, grp, now, sec, dev};
    do @(posedge clk_i); while (!s_axis_tready);
    acct_q.push_back(account_event(op, dev, sec, now, grp, kind, nb, nsec, fail));
    if (!op) live_keys.push_back({dev, sec});
    @(negedge clk_i);
  endtask

  // result checker: compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (acct_q.size() == 0) begin
        failed_any = 1;
        if (mism++ < 10) $display("unexpected word status=%0d", m_axis_tuser);
      end else begin
        acct_word_t e;
        e = acct_q.pop_front();
        if (e[330:328] !== m_axis_tuser || e[327:0] !== m_axis_tdata) begin
          failed_any = 1;
          if (mism++ < 10)
            $display("mismatch: exp st=%0d data=%h got st=%0d data=%h",
                     e[330:328], e[327:0], m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  // receiver stall pattern; long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 3) == 0);
  end

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (acct_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_kind();
    case ($urandom_range(0, 3))
      0: return KIND_WRITE;
      1: return KIND_DISCARD;
      default: return 8'($urandom);
    endcase
  endfunction

  // random issue/complete traffic over a small key space
  task automatic random_ops(int n, int ngrp);
    logic [63:0] k, now;
    int idx;
    now = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      now += $urandom_range(0, 5000);
      if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
      if (live_keys.size() > 0 && $urandom_range(0, 1) == 0) begin
        idx = $urandom_range(0, live_keys.size() - 1);
        k = live_keys[idx];
        live_keys.delete(idx);
        send_word(1, k[63:32], k[31:0], now, {$urandom, $urandom}, 8'($urandom), $urandom,
                  23'($urandom), $urandom_range(0, 9) == 0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_word(1, $urandom, $urandom, now, {$urandom, $urandom}, 8'($urandom), $urandom,
                  23'($urandom), 1'($urandom));
      end else begin
        send_word(0, $urandom_range(0, 3), $urandom_range(0, 40), now,
                  grp_pool[$urandom_range(0, ngrp - 1)], rand_kind(),
                  ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom, 23'($urandom),
                  1'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    logic [63:0] g;
    g = '1;
    send_word(1, 32'd5, 32'd5, 64'd0, g, 8'd0, 0, 0, 0);                  // unmatched
    send_word(0, '1, '1, '1, g, KIND_WRITE, '1, 0, 0);                    // extremes
    send_word(0, '1, '1, 64'd7, g, KIND_DISCARD, 0, '1, 1);               // same key overwrite
    send_word(1, '1, '1, 64'd3, 64'd0, 8'd0, 0, 0, 0);                    // latency wraps
    send_word(0, 0, 0, 64'd100, 64'd0, 8'h52, 0, 23'd8, 0);               // read, sectors
    send_word(1, 0, 0, 64'd250, 64'd9, 8'd0, 0, 0, 1);                    // failed completion
    send_word(0, 0, 0, 64'd100, 64'd0, 8'hFF, 32'h1, 0, 0);
    send_word(1, 0, 0, 64'd0, 64'd0, 8'd0, 0, 0, 0);
    drain();
  endtask

  // fill pending table past its depth, then free it
  task automatic test_pending_full();
    for (int i = 0; i < PendN + 4; i++)
      send_word(0, 32'd77, i, 64'(i), 64'd1, KIND_WRITE, 32'd4096, 0, 0);
    for (int i = 0; i < PendN + 4; i++)
      send_word(1, 32'd77, i, 64'(i * 3), 64'd0, 8'd0, 0, 0, i % 9 == 0);
    drain();
  endtask

  // more groups than the stats table holds
  task automatic test_stats_full();
    for (int i = 0; i < GrpN + 4; i++) begin
      send_word(0, 32'd88, i, 64'd10, 64'(1000 + i), 8'h52, 32'd512, 0, 0);
      send_word(1, 32'd88, i, 64'd50, 64'd0, 8'd0, 0, 0, 0);
    end
    drain();
  endtask

  // receiver held off while the sender keeps offering words
  task automatic test_backpressure();
    hold_rx = 1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_rx = 0;
      end
      random_ops(40, 24);
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < PendN; i++) pv[i] = 0;
    for (int i = 0; i < GrpN; i++) gv[i] = 0;
    for (int i = 0; i < 24; i++) grp_pool[i] = (i == 0) ? '1 : {$urandom, $urandom};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_pending_full();
    test_stats_full();
    live_keys.delete();
    random_ops(1400, 24);
    test_backpressure();
    random_ops(200, 8);
    drain();
    repeat (200) @(posedge clk_i);
    if (!failed_any && acct_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
design/bla_pkg.sv
design/bla_ctrl.sv
design/bla_dp.sv
design/block_io_latency_accounting.sv
bench/block_io_latency_accounting_tb.sv
